/* rtl/apu_pkg.sv */
// Shared types and constants for the alpha plane unfilter block.
package apu_pkg;

  localparam int RES_W    = 8;
  localparam int HDR_W    = 8;
  localparam int LWID_W   = 13;
  localparam int HGT_W    = 15;
  localparam int ROW_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [HGT_W-1:0] MAX_HEIGHT = 15'd16384;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Highest legal codes of the compression and preprocessing fields, and the required reserved value.
  localparam logic [1:0] COMP_MAX_LEGAL = 2'd1;
  localparam logic [1:0] PREP_MAX_LEGAL = 2'd1;
  localparam logic [1:0] RESERVED_OK    = 2'd0;

  localparam logic [RES_W-1:0] PIX_MAX = 8'd255;

  typedef enum logic [1:0] {
    FILT_NONE  = 2'd0,
    FILT_HORIZ = 2'd1,
    FILT_VERT  = 2'd2,
    FILT_GRAD  = 2'd3
  } filter_t;

  // Position flags of one pixel, passed from the position counters.
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic eoi;
  } pos_flags_t;

  // Decoded header fields.
  typedef struct packed {
    filter_t filter;
    logic    err;
  } hdr_dec_t;

  function automatic hdr_dec_t decode_header(input logic [HDR_W-1:0] hdr);
    hdr_dec_t d;
    d.filter = filter_t'(hdr[3:2]);
    d.err    = (hdr[7:6] != RESERVED_OK) || (hdr[1:0] > COMP_MAX_LEGAL) ||
               (hdr[5:4] > PREP_MAX_LEGAL);
    return d;
  endfunction

endpackage

/* rtl/apu_stream_if.sv */
// Valid/ready stream interfaces for residual input and alpha output.
interface apu_in_if;
  logic                    valid;
  logic                    ready;
  logic [apu_pkg::RES_W-1:0] residual;

  modport source (output valid, output residual, input ready);
  modport sink   (input valid, input residual, output ready);
endinterface

interface apu_out_if;
  logic                    valid;
  logic                    ready;
  logic [apu_pkg::RES_W-1:0] alpha_value;
  logic                    end_of_image;
  logic                    header_error;

  modport source (output valid, output alpha_value, output end_of_image,
                  output header_error, input ready);
  modport sink   (input valid, input alpha_value, input end_of_image,
                  input header_error, output ready);
endinterface

/* rtl/alpha_plane_unfilter.sv */
// Alpha plane unfilter: one residual byte in, one reconstructed alpha byte out.
// An accepted residual passes through the stage 1 register and the output register.
// Throughput: one pixel per cycle when not stalled; the line store read is issued at
// accept and written back as the pixel leaves stage 1, forwarding the pending pixel.
// Reset (synchronous, active low) clears position, neighbors and registers;
// the line store is not cleared and needs no clearing pass.
module alpha_plane_unfilter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  apu_in_if.sink                         in_ch,
  apu_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [apu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [apu_pkg::HDR_W-1:0]  header_r;
  logic [apu_pkg::LWID_W-1:0] width_r;
  logic [apu_pkg::HGT_W-1:0]  height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      width_r  <= apu_pkg::LWID_W'(1);
      height_r <= apu_pkg::HGT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        apu_pkg::REG_HEADER: header_r <= cfg_wdata[apu_pkg::HDR_W-1:0];
        apu_pkg::REG_WIDTH:  width_r  <= cfg_wdata[apu_pkg::LWID_W-1:0];
        apu_pkg::REG_HEIGHT: height_r <= cfg_wdata[apu_pkg::HGT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  apu_pkg::hdr_dec_t hdr;
  assign hdr = apu_pkg::decode_header(header_r);

  // Pipeline control.
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Position of the pixel being accepted.
  logic [CW-1:0]       pos_x;
  apu_pkg::pos_flags_t pos_flags;

  apu_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_acc),
    .line_width   (width_r),
    .image_height (height_r),
    .x            (pos_x),
    .flags        (pos_flags)
  );

  // Stage 1 holds the pixel whose line store data arrives this cycle.
  logic [CW-1:0]             s1_x_r;
  apu_pkg::pos_flags_t       s1_flags_r;
  logic [apu_pkg::RES_W-1:0] s1_res_r;
  logic                      fwd_hit_r;
  logic [apu_pkg::RES_W-1:0] fwd_val_r;
  logic [apu_pkg::RES_W-1:0] left_r;
  logic [apu_pkg::RES_W-1:0] corner_r;
  logic [apu_pkg::RES_W-1:0] mem_rdata;
  logic [apu_pkg::RES_W-1:0] above_raw;
  logic [apu_pkg::RES_W-1:0] above;
  logic [apu_pkg::RES_W-1:0] s1_val;

  apu_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_x_r),
    .wdata (s1_val),
    .re    (in_acc),
    .raddr (pos_x),
    .rdata (mem_rdata)
  );

  // The pixel written back on the accept edge is forwarded when the new pixel
  // reads the same column, since the store returns the old byte then.
  assign above_raw = fwd_hit_r ? fwd_val_r : mem_rdata;
  assign above     = s1_flags_r.y_zero ? '0 : above_raw;

  apu_predictor u_predictor (
    .hdr      (hdr),
    .flags    (s1_flags_r),
    .residual (s1_res_r),
    .left     (left_r),
    .above    (above),
    .corner   (corner_r),
    .value    (s1_val)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= pos_x;
      s1_flags_r <= pos_flags;
      s1_res_r   <= in_ch.residual;
      fwd_hit_r  <= s1_valid_r && (pos_x == s1_x_r);
      fwd_val_r  <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      left_r     <= '0;
      corner_r   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        left_r   <= s1_val;
        corner_r <= above;
      end
    end
  end

  // Output register.
  logic [apu_pkg::RES_W-1:0] out_alpha_r;
  logic                      out_eoi_r;
  logic                      out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_alpha_r <= s1_val;
      out_eoi_r   <= s1_flags_r.eoi;
      out_err_r   <= hdr.err;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.alpha_value  = out_alpha_r;
  assign out_ch.end_of_image = out_eoi_r;
  assign out_ch.header_error = out_err_r;

  // A new transaction only enters stage 1 when its occupant moves on.
  a_no_s1_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_valid_r |-> s1_adv)
    else $error("stage 1 overwritten before it advanced");

  // The output register is never loaded while a result is still pending.
  a_no_out_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |-> !out_valid_r || out_ch.ready)
    else $error("output register overwritten while stalled");

  // A header error always delivers a zero alpha byte.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_alpha_r == '0)
    else $error("header error with nonzero alpha");

  // A same-column read while stage 1 writes back on the accept is always forwarded.
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_valid_r && (pos_x == s1_x_r) |=> fwd_hit_r && s1_valid_r)
    else $error("same-column read not forwarded");

endmodule

/* rtl/apu_line_store.sv */
// Single-port-write, single-port-read line store with registered read data.
module apu_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [apu_pkg::RES_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [apu_pkg::RES_W-1:0] rdata
);

  logic [apu_pkg::RES_W-1:0] mem [DEPTH];
  logic [apu_pkg::RES_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/apu_position.sv */
// Column and row counters that place each pixel in the plane.
module apu_position #(
  parameter int MAX_WIDTH = 4096,
  parameter int CW        = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [apu_pkg::LWID_W-1:0] line_width,
  input  logic [apu_pkg::HGT_W-1:0]  image_height,
  output logic [CW-1:0]              x,
  output apu_pkg::pos_flags_t        flags
);

  localparam logic [apu_pkg::HGT_W-1:0] MAXW = apu_pkg::HGT_W'(MAX_WIDTH);

  logic [CW-1:0]               col_r, col_nxt;
  logic [apu_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [apu_pkg::HGT_W-1:0]   lw_ext;
  logic [CW:0]                 w_eff;
  logic [apu_pkg::HGT_W-1:0]   h_eff;
  logic [apu_pkg::HGT_W-1:0]   row_tmp;
  logic [apu_pkg::ROW_W-1:0]   y;
  logic [CW:0]                 x_inc;
  logic [apu_pkg::HGT_W-1:0]   y_inc;

  always_comb begin
    lw_ext = {{(apu_pkg::HGT_W-apu_pkg::LWID_W){1'b0}}, line_width};
    if (lw_ext == '0) begin
      w_eff = (CW+1)'(1);
    end else if (lw_ext > MAXW) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = lw_ext[CW:0];
    end

    if (image_height == '0) begin
      h_eff = apu_pkg::HGT_W'(1);
    end else if (image_height > apu_pkg::MAX_HEIGHT) begin
      h_eff = apu_pkg::MAX_HEIGHT;
    end else begin
      h_eff = image_height;
    end

    // A column past the row end, left by a narrowed width, starts a new row.
    if ({1'b0, col_r} >= w_eff) begin
      x       = '0;
      row_tmp = {1'b0, row_r} + apu_pkg::HGT_W'(1);
    end else begin
      x       = col_r;
      row_tmp = {1'b0, row_r};
    end
    y = (row_tmp >= h_eff) ? '0 : row_tmp[apu_pkg::ROW_W-1:0];

    x_inc = {1'b0, x} + (CW+1)'(1);
    y_inc = {1'b0, y} + apu_pkg::HGT_W'(1);

    flags.x_zero = (x == '0);
    flags.y_zero = (y == '0);
    flags.eoi    = (x_inc == w_eff) && (y_inc == h_eff);

    if (x_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (y_inc >= h_eff) ? '0 : y_inc[apu_pkg::ROW_W-1:0];
    end else begin
      col_nxt = x_inc[CW-1:0];
      row_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/apu_predictor.sv */
// Predictor selection and reconstruction of one alpha byte.
module apu_predictor (
  input  apu_pkg::hdr_dec_t         hdr,
  input  apu_pkg::pos_flags_t       flags,
  input  logic [apu_pkg::RES_W-1:0] residual,
  input  logic [apu_pkg::RES_W-1:0] left,
  input  logic [apu_pkg::RES_W-1:0] above,
  input  logic [apu_pkg::RES_W-1:0] corner,
  output logic [apu_pkg::RES_W-1:0] value
);

  logic signed [apu_pkg::RES_W+1:0] grad;
  logic [apu_pkg::RES_W-1:0]        grad_clip;
  logic [apu_pkg::RES_W-1:0]        pred;

  always_comb begin
    grad = $signed({2'b00, left}) + $signed({2'b00, above}) -
           $signed({2'b00, corner});
    if (grad < 0) begin
      grad_clip = '0;
    end else if (grad > $signed({2'b00, apu_pkg::PIX_MAX})) begin
      grad_clip = apu_pkg::PIX_MAX;
    end else begin
      grad_clip = grad[apu_pkg::RES_W-1:0];
    end

    pred = '0;
    case (hdr.filter)
      apu_pkg::FILT_NONE: begin
        pred = '0;
      end
      apu_pkg::FILT_HORIZ: begin
        if (!flags.x_zero) pred = left;
        else if (!flags.y_zero) pred = above;
      end
      apu_pkg::FILT_VERT: begin
        if (!flags.y_zero) pred = above;
        else if (!flags.x_zero) pred = left;
      end
      apu_pkg::FILT_GRAD: begin
        if (!flags.x_zero && !flags.y_zero) pred = grad_clip;
        else if (!flags.x_zero) pred = left;
        else if (!flags.y_zero) pred = above;
      end
      default: begin
        pred = '0;
      end
    endcase

    value = hdr.err ? '0 : pred + residual;
  end

endmodule
